FILE: design/gfc_pkg.sv
// shared types and constants of the gated frequency counter
`timescale 1ns / 1ps
`default_nettype none

package gfc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int RATE_W      = 10;
    localparam int FREQ_W      = 32;
    localparam int MANT_W      = 15;
    localparam int SCALE_W     = 3;
    localparam int PROD_W      = (COUNT_WIDTH + RATE_W > FREQ_W) ?
                                 COUNT_WIDTH + RATE_W : FREQ_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(10);
    localparam logic [FREQ_W-1:0]  HYST_RESET = FREQ_W'(10);
    localparam logic [FREQ_W-1:0]  FREQ_MAX   = '1;
    localparam logic [FREQ_W-1:0]  MANT_LIMIT = FREQ_W'(32767);
    localparam logic [SCALE_W-1:0] SCALE_MAX  = SCALE_W'(6);
    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
    localparam logic [FREQ_W-1:0]  DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    typedef enum logic {
        REG_RATE = 1'b0,
        REG_HYST = 1'b1
    } gfc_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPDATE,
        S_HYST,
        S_SCALE,
        S_EMIT
    } gfc_state_t;

    typedef struct packed {
        logic edge_seen;
        logic gate_close;
    } gfc_in_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  frequency_hz;
        logic [MANT_W-1:0]  mantissa;
        logic [SCALE_W-1:0] decimal_scale;
        logic               change_event;
        logic               window_done;
    } gfc_out_t;

    // one classified tick: plain tick or window close with its edge count
    typedef struct packed {
        logic                   gate;
        logic [COUNT_WIDTH-1:0] count;
    } gfc_entry_t;

endpackage

`default_nettype wire

FILE: design/gfc_front.sv
// front end: takes ticks, keeps the saturating edge count, classifies
`timescale 1ns / 1ps
`default_nettype none

module gfc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire gfc_pkg::gfc_in_t    s_data,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output gfc_pkg::gfc_entry_t      push_entry
);

    logic [gfc_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [gfc_pkg::COUNT_WIDTH-1:0] count_next;
    logic [gfc_pkg::COUNT_WIDTH-1:0] count_inc;

    always_comb begin
        count_inc = count_reg;
        if (s_data.edge_seen && (count_reg != '1)) begin
            count_inc = count_reg + gfc_pkg::COUNT_WIDTH'(1);
        end
        count_next = count_reg;
        if (s_valid && push_ready) begin
            count_next = s_data.gate_close ? '0 : count_inc;
        end
    end

    assign s_ready          = push_ready;
    assign push_valid       = s_valid;
    assign push_entry.gate  = s_data.gate_close;
    assign push_entry.count = count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/gfc_queue.sv
// short request queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module gfc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire gfc_pkg::gfc_entry_t  push_entry,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output gfc_pkg::gfc_entry_t       pop_entry
);

    gfc_pkg::gfc_entry_t            mem_reg [gfc_pkg::QUEUE_DEPTH];
    logic [gfc_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [gfc_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [gfc_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [gfc_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [gfc_pkg::QUEUE_AW:0]     fill_reg;
    logic [gfc_pkg::QUEUE_AW:0]     fill_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (fill_reg != (gfc_pkg::QUEUE_AW+1)'(gfc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + gfc_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + gfc_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (gfc_pkg::QUEUE_AW+1)'(1);
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - (gfc_pkg::QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/gfc_back.sv
// back end: window evaluation, deadband, hysteresis, mantissa and result register
`timescale 1ns / 1ps
`default_nettype none

module gfc_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire gfc_pkg::gfc_entry_t          pop_entry,
    input  wire logic [gfc_pkg::RATE_W-1:0]   rate,
    input  wire logic [gfc_pkg::FREQ_W-1:0]   hyst,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output gfc_pkg::gfc_out_t                 m_data
);

    gfc_pkg::gfc_state_t                state_reg, state_next;
    logic [gfc_pkg::COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [gfc_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [gfc_pkg::FREQ_W-1:0]         cur_reg, cur_next;
    logic [gfc_pkg::FREQ_W-1:0]         last_reg, last_next;
    logic [gfc_pkg::FREQ_W-1:0]         val_reg, val_next;
    logic [gfc_pkg::SCALE_W-1:0]        scale_reg, scale_next;
    logic                               event_reg, event_next;
    logic [gfc_pkg::MANT_W-1:0]         mant_cache_reg, mant_cache_next;
    logic [gfc_pkg::SCALE_W-1:0]        scale_cache_reg, scale_cache_next;
    logic                               out_valid_reg, out_valid_next;
    gfc_pkg::gfc_out_t                  out_data_reg, out_data_next;

    logic                               out_free;
    logic [gfc_pkg::FREQ_W-1:0]         raw;
    logic [gfc_pkg::FREQ_W-1:0]         diff;
    logic [2*gfc_pkg::FREQ_W-1:0]       div_prod;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign div_prod = (2*gfc_pkg::FREQ_W)'(val_reg) * (2*gfc_pkg::FREQ_W)'(gfc_pkg::DIV10_RECIP);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        prod_next        = prod_reg;
        cur_next         = cur_reg;
        last_next        = last_reg;
        val_next         = val_reg;
        scale_next       = scale_reg;
        event_next       = event_reg;
        mant_cache_next  = mant_cache_reg;
        scale_cache_next = scale_cache_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_data_next    = out_data_reg;
        pop_ready        = 1'b0;
        raw              = (prod_reg > gfc_pkg::PROD_W'(gfc_pkg::FREQ_MAX)) ?
                           gfc_pkg::FREQ_MAX : prod_reg[gfc_pkg::FREQ_W-1:0];
        diff             = '0;

        unique case (state_reg)
            gfc_pkg::S_IDLE: begin
                if (pop_valid) begin
                    if (pop_entry.gate) begin
                        pop_ready  = 1'b1;
                        count_next = pop_entry.count;
                        state_next = gfc_pkg::S_MUL;
                    end else if (out_free) begin
                        // plain tick reports the stored frequency as is
                        pop_ready                   = 1'b1;
                        out_valid_next              = 1'b1;
                        out_data_next.frequency_hz  = cur_reg;
                        out_data_next.mantissa      = mant_cache_reg;
                        out_data_next.decimal_scale = scale_cache_reg;
                        out_data_next.change_event  = 1'b0;
                        out_data_next.window_done   = 1'b0;
                    end
                end
            end
            gfc_pkg::S_MUL: begin
                prod_next  = gfc_pkg::PROD_W'(count_reg) * gfc_pkg::PROD_W'(rate);
                state_next = gfc_pkg::S_UPDATE;
            end
            gfc_pkg::S_UPDATE: begin
                // noise deadband
                diff = (raw > cur_reg) ? raw - cur_reg : cur_reg - raw;
                if (diff > gfc_pkg::FREQ_W'(rate)) begin
                    cur_next = raw;
                end
                state_next = gfc_pkg::S_HYST;
            end
            gfc_pkg::S_HYST: begin
                diff = (cur_reg > last_reg) ? cur_reg - last_reg : last_reg - cur_reg;
                event_next = (diff > hyst);
                if (diff > hyst) begin
                    last_next = cur_reg;
                end
                val_next   = cur_reg;
                scale_next = '0;
                state_next = gfc_pkg::S_SCALE;
            end
            gfc_pkg::S_SCALE: begin
                // one divide by ten per cycle
                if (val_reg > gfc_pkg::MANT_LIMIT) begin
                    val_next   = gfc_pkg::FREQ_W'(div_prod[2*gfc_pkg::FREQ_W-1:gfc_pkg::DIV10_SHIFT]);
                    scale_next = scale_reg + gfc_pkg::SCALE_W'(1);
                end else begin
                    state_next = gfc_pkg::S_EMIT;
                end
            end
            gfc_pkg::S_EMIT: begin
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.frequency_hz  = cur_reg;
                    out_data_next.mantissa      = val_reg[gfc_pkg::MANT_W-1:0];
                    out_data_next.decimal_scale = scale_reg;
                    out_data_next.change_event  = event_reg;
                    out_data_next.window_done   = 1'b1;
                    mant_cache_next             = val_reg[gfc_pkg::MANT_W-1:0];
                    scale_cache_next            = scale_reg;
                    state_next                  = gfc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gfc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= gfc_pkg::S_IDLE;
            cur_reg         <= '0;
            last_reg        <= '0;
            mant_cache_reg  <= '0;
            scale_cache_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            last_reg        <= last_next;
            mant_cache_reg  <= mant_cache_next;
            scale_cache_reg <= scale_cache_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        prod_reg     <= prod_next;
        val_reg      <= val_next;
        scale_reg    <= scale_next;
        event_reg    <= event_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_event_only_on_window: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.window_done |-> !out_data_reg.change_event)
        else $error("change event on a tick that closed no window");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.decimal_scale <= gfc_pkg::SCALE_MAX)
        else $error("decimal scale out of range");

    a_mantissa_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gfc_pkg::S_EMIT |-> val_reg <= gfc_pkg::MANT_LIMIT)
        else $error("mantissa not reduced before emit");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready |-> state_reg == gfc_pkg::S_IDLE)
        else $error("queue popped while a window is in progress");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: design/gated_frequency_counter.sv
// Gated edge frequency counter, top level with configuration registers.
// Plain ticks pass the request queue and the result register; a window-closing tick also
// passes back end states MUL, UPDATE, HYST, SCALE (0..6 divides by ten) and EMIT.
// Throughput: one plain tick per cycle while the back end is idle and the output is taken;
// a window close occupies the back end while the 4-entry request queue takes ticks until full.
// Reset (aresetn low, synchronous) clears count, frequencies and queue, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module gated_frequency_counter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire gfc_pkg::gfc_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output gfc_pkg::gfc_out_t                  m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gfc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gfc_pkg::DATA_W-1:0]    pwdata,
    output logic [gfc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic [gfc_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [gfc_pkg::FREQ_W-1:0] hyst_reg, hyst_next;
    gfc_pkg::gfc_reg_t          reg_sel;
    logic                       cfg_write;

    logic                       push_valid;
    logic                       push_ready;
    gfc_pkg::gfc_entry_t        push_entry;
    logic                       pop_valid;
    logic                       pop_ready;
    gfc_pkg::gfc_entry_t        pop_entry;

    assign pready    = 1'b1;
    assign reg_sel   = gfc_pkg::gfc_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        rate_next = rate_reg;
        hyst_next = hyst_reg;
        prdata    = '0;
        unique case (reg_sel)
            gfc_pkg::REG_RATE: begin
                prdata = gfc_pkg::DATA_W'(rate_reg);
                if (cfg_write) begin
                    rate_next = pwdata[gfc_pkg::RATE_W-1:0];
                end
            end
            gfc_pkg::REG_HYST: begin
                prdata = hyst_reg;
                if (cfg_write) begin
                    hyst_next = pwdata;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= gfc_pkg::RATE_RESET;
            hyst_reg <= gfc_pkg::HYST_RESET;
        end else begin
            rate_reg <= rate_next;
            hyst_reg <= hyst_next;
        end
    end

    gfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    gfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    gfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .rate      (rate_reg),
        .hyst      (hyst_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
